[sv/char_hamming_crc_encoder_top_defines.svh]
// Assertion macros for the character Hamming/CRC encoder.
`ifndef CHAR_HAMMING_CRC_ENCODER_TOP_DEFINES_SVH
`define CHAR_HAMMING_CRC_ENCODER_TOP_DEFINES_SVH

// property checked outside reset
`define CHCE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property that also covers the reset cycles
`define CHCE_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

[sv/chce_pkg.sv]
// Shared types and constants for the character Hamming/CRC encoder.
package chce_pkg;

   localparam int BYTES_PER_CHAR = 3;
   localparam int SEL_W          = $clog2(BYTES_PER_CHAR);
   localparam logic [SEL_W-1:0] SEL_FIRST = SEL_W'(0);
   localparam logic [SEL_W-1:0] SEL_MID   = SEL_W'(1);
   localparam logic [SEL_W-1:0] SEL_LAST  = SEL_W'(BYTES_PER_CHAR - 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE_SELECT = 2'd0,
      CSR_DATA_WIDTH  = 2'd1
   } csr_index_type;

   localparam logic       MODE_HAMMING   = 1'b0;
   localparam logic       MODE_CRC       = 1'b1;
   localparam logic [3:0] WIDTH_SEVEN    = 4'd7;
   localparam logic [3:0] WIDTH_RESET    = 4'd8;
   localparam logic [7:0] LEN_SHORT      = 8'd11;
   localparam logic [7:0] LEN_LONG       = 8'd12;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_MSB  = 16'h8000;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // three payload bytes of one character, b0 goes out first
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } entry_type;

endpackage

[sv/chce_front.sv]
// Front end: config registers, request intake and per-character encoding.
module chce_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_char_byte,
   input  logic                              csr_valid,
   input  logic [chce_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [chce_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              q_full,
   output logic                              push,
   output chce_pkg::entry_type               push_entry
);

   logic       mode_ff, mode_in;
   logic [3:0] width_ff, width_in;

   function automatic logic [15:0] crc_byte(input logic [7:0] b);
      logic [15:0] c;
      c = chce_pkg::CRC_INIT ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & chce_pkg::CRC_MSB) != 16'h0000)
            c = {c[14:0], 1'b0} ^ chce_pkg::CRC_POLY;
         else
            c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // codeword bit p-1 holds position p
   function automatic logic [11:0] hamming_word(input logic [7:0] d);
      logic [11:0] w;
      w[0]  = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
      w[1]  = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
      w[2]  = d[0];
      w[3]  = d[1] ^ d[2] ^ d[3] ^ d[7];
      w[4]  = d[1];
      w[5]  = d[2];
      w[6]  = d[3];
      w[7]  = d[4] ^ d[5] ^ d[6] ^ d[7];
      w[8]  = d[4];
      w[9]  = d[5];
      w[10] = d[6];
      w[11] = d[7];
      return w;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      width_in = width_ff;
      if (csr_valid) begin
         case (csr_index)
            chce_pkg::CSR_MODE_SELECT: mode_in  = csr_data[0];
            chce_pkg::CSR_DATA_WIDTH:  width_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= chce_pkg::MODE_HAMMING;
         width_ff <= chce_pkg::WIDTH_RESET;
      end else begin
         mode_ff  <= mode_in;
         width_ff <= width_in;
      end
   end

   logic        short_word;
   logic [7:0]  ham_data;
   logic [11:0] word;
   logic [15:0] crc;

   assign short_word = (width_ff == chce_pkg::WIDTH_SEVEN);
   assign ham_data   = short_word ? {1'b0, req_char_byte[6:0]} : req_char_byte;
   assign word       = hamming_word(ham_data);
   assign crc        = crc_byte(req_char_byte);

   always_comb begin
      if (mode_ff == chce_pkg::MODE_CRC) begin
         push_entry.b0 = req_char_byte;
         push_entry.b1 = crc[15:8];
         push_entry.b2 = crc[7:0];
      end else begin
         push_entry.b0 = short_word ? chce_pkg::LEN_SHORT : chce_pkg::LEN_LONG;
         push_entry.b1 = word[7:0];
         push_entry.b2 = {4'b0000, word[11:8]};
      end
   end

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

endmodule

[sv/chce_queue.sv]
// Two-entry queue of encoded characters between front and back end.
module chce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  chce_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                q_full,
   output logic                q_valid,
   output chce_pkg::entry_type head_entry
);

   chce_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_full     = (count_ff == 2'd2);
   assign q_valid    = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 2'd1;
      else if (pop && !push)
         count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

[sv/chce_back.sv]
// Back end: serializes the queue head onto the byte-wide response channel.
module chce_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  chce_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_byte
);

   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in;
   logic [chce_pkg::SEL_W-1:0] sel_ff, sel_in;
   logic                       advance;
   logic                       at_last;

   // output register frees up when empty or its transaction completes
   assign advance = !valid_ff || rsp_ready;
   assign at_last = (sel_ff == chce_pkg::SEL_LAST);
   assign pop     = advance && q_valid && at_last;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      sel_in   = sel_ff;
      if (advance) begin
         valid_in = q_valid;
         last_in  = at_last;
         case (sel_ff)
            chce_pkg::SEL_FIRST: byte_in = head_entry.b0;
            chce_pkg::SEL_MID:   byte_in = head_entry.b1;
            default:             byte_in = head_entry.b2;
         endcase
         if (q_valid)
            sel_in = at_last ? chce_pkg::SEL_FIRST : sel_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= chce_pkg::SEL_FIRST;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

[sv/char_hamming_crc_encoder_top.sv]
// Top level of the character Hamming/CRC encoder.
//
//   channel | ports                                   | direction
//   req     | req_valid req_ready req_char_byte       | in
//   rsp     | rsp_valid rsp_ready rsp_out_byte/last   | out
//   csr     | csr_valid csr_ready csr_index csr_data  | in
//
// Each character yields three response bytes, one per cycle while rsp_ready is
// held high; the sustained character rate is set by the byte-wide output serializer.
// A character is encoded in the cycle it is accepted and written into the queue;
// its first byte is then loaded into the output register. Up to two encoded characters
// wait in the queue, so requests are still taken while the response side stalls until it is full.
// Reset (synchronous) empties the queue and output stage and sets Hamming mode
// with 8 data bits.
module char_hamming_crc_encoder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_char_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_byte,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [chce_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [chce_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic                q_full;
   logic                q_valid;
   logic                push;
   logic                pop;
   chce_pkg::entry_type push_entry;
   chce_pkg::entry_type head_entry;

   assign csr_ready = 1'b1;

   chce_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_byte (req_char_byte),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_full        (q_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   chce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .head_entry (head_entry)
   );

   chce_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

[sv/chce_checker.sv]
// Port-level checker for the encoder top, attached by bind.
`include "char_hamming_crc_encoder_top_defines.svh"

module chce_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [7:0]                        rsp_out_byte,
   input logic                              rsp_last_byte
);

   // characters accepted whose last byte has not yet completed
   logic [2:0] pending_ff, pending_in;
   logic       req_xfer;
   logic       done_xfer;

   assign req_xfer  = req_valid && req_ready;
   assign done_xfer = rsp_valid && rsp_ready && rsp_last_byte;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !done_xfer)
         pending_in = pending_ff + 3'd1;
      else if (done_xfer && !req_xfer)
         pending_in = pending_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         pending_ff <= 3'd0;
      else
         pending_ff <= pending_in;
   end

   `CHCE_ASSERT(rsp_hold_a, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte),
      "response changed while stalled")

   `CHCE_ASSERT_RST(rsp_reset_a, clock, reset |=> !rsp_valid,
      "response valid right after reset")

   `CHCE_ASSERT(rsp_pending_a, clock, reset, rsp_valid |-> pending_ff != 3'd0,
      "response byte without an outstanding character")

   `CHCE_ASSERT(pending_bound_a, clock, reset, pending_ff <= 3'd3,
      "more characters in flight than the queue and output stage hold")

endmodule

bind char_hamming_crc_encoder_top chce_checker u_chce_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the character Hamming/CRC encoder top level.
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_CHARS = 430;
   localparam int CYCLE_LIMIT  = 200000;

   // Holds the encoder's settings and the payload bytes still owed by the block.
   class payload_board_type;
      typedef struct {
         logic [7:0] value;
         logic       last;
      } payload_byte_type;

      logic             mode;
      logic [3:0]       width;
      payload_byte_type owed_bytes[$];
      int               errors;

      function new();
         mode   = chce_pkg::MODE_HAMMING;
         width  = chce_pkg::WIDTH_RESET;
         errors = 0;
      endfunction

      function void write_reg(chce_pkg::csr_index_type idx,
                              logic [chce_pkg::CSR_DATA_W-1:0] value);
         if (idx == chce_pkg::CSR_MODE_SELECT)
            mode = value[0];
         else if (idx == chce_pkg::CSR_DATA_WIDTH)
            width = value;
      endfunction

      function int pending();
         return owed_bytes.size();
      endfunction

      function void owe_byte(logic [7:0] value, logic last);
         payload_byte_type item;
         item.value = value;
         item.last  = last;
         owed_bytes.insert(owed_bytes.size(), item);
      endfunction

      function logic [11:0] hamming_codeword(logic [7:0] data, int n);
         logic [11:0] word;
         int          k;
         int          pos;
         int          b;
         logic        par;
         word = '0;
         k = 0;
         for (pos = 1; pos <= n; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
               word[pos-1] = data[k];
               k++;
            end
         end
         for (b = 0; b < 4; b++) begin
            par = 1'b0;
            for (pos = 1; pos <= n; pos++)
               if ((pos & (1 << b)) != 0)
                  par ^= word[pos-1];
            word[(1 << b) - 1] = par;
         end
         return word;
      endfunction

      function logic [15:0] crc_ccitt(logic [7:0] ch);
         logic [15:0] crc;
         int          i;
         crc = chce_pkg::CRC_INIT ^ {ch, 8'h00};
         for (i = 0; i < 8; i++) begin
            if ((crc & chce_pkg::CRC_MSB) != 0)
               crc = (crc << 1) ^ chce_pkg::CRC_POLY;
            else
               crc = crc << 1;
         end
         return crc;
      endfunction

      // Works out the three bytes owed for one accepted character.
      function void note_char(logic [7:0] ch);
         chce_pkg::entry_type entry;
         logic [15:0]         crc;
         logic [11:0]         word;
         logic                short_word;
         if (mode == chce_pkg::MODE_CRC) begin
            crc = crc_ccitt(ch);
            entry.b0 = ch;
            entry.b1 = crc[15:8];
            entry.b2 = crc[7:0];
         end else begin
            // any width code but seven means eight data bits
            short_word = (width == chce_pkg::WIDTH_SEVEN);
            if (short_word)
               word = hamming_codeword({1'b0, ch[6:0]}, 11);
            else
               word = hamming_codeword(ch, 12);
            entry.b0 = short_word ? chce_pkg::LEN_SHORT : chce_pkg::LEN_LONG;
            entry.b1 = word[7:0];
            entry.b2 = {4'h0, word[11:8]};
         end
         owe_byte(entry.b0, 1'b0);
         owe_byte(entry.b1, 1'b0);
         owe_byte(entry.b2, 1'b1);
      endfunction

      function void check_byte(logic [7:0] out_byte, logic last_byte);
         payload_byte_type owed;
         if (owed_bytes.size() == 0) begin
            $error("unexpected transaction: out_byte %0h last_byte %0b", out_byte, last_byte);
            errors++;
            return;
         end
         owed = owed_bytes.pop_front();
         if (out_byte !== owed.value) begin
            $error("out_byte mismatch: expected %02h, actual %02h", owed.value, out_byte);
            errors++;
         end
         if (last_byte !== owed.last) begin
            $error("last_byte mismatch: expected %0b, actual %0b", owed.last, last_byte);
            errors++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [7:0]                       req_char_byte;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [7:0]                       rsp_out_byte;
   logic                             rsp_last_byte;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [chce_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [chce_pkg::CSR_DATA_W-1:0]  csr_data;

   payload_board_type board = new();
   int                cycles = 0;
   logic              req_calm = 1'b0;
   logic              rsp_calm = 1'b0;

   char_hamming_crc_encoder_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_byte (req_char_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // register writes, accepted characters and returned bytes, in that order
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.write_reg(chce_pkg::csr_index_type'(csr_index), csr_data);
         if (req_valid && req_ready)
            board.note_char(req_char_byte);
         if (rsp_valid && rsp_ready)
            board.check_byte(rsp_out_byte, rsp_last_byte);
      end
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL char_hamming_crc_encoder_top");
         $finish;
      end
   end

   // stretches where one side or the other runs without idling
   initial begin
      forever begin
         repeat (40) @(posedge clock);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send_char(input logic [7:0] ch);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= ch;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_list(input logic [7:0] chars[$]);
      foreach (chars[i])
         send_char(chars[i]);
   endtask

   // drop valid and hold off until every owed byte is back
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_config(input logic [3:0] mode_data, input logic [3:0] width_data);
      csr_valid <= 1'b1;
      csr_index <= chce_pkg::CSR_MODE_SELECT;
      csr_data  <= mode_data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= chce_pkg::CSR_DATA_WIDTH;
      csr_data  <= width_data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] chars[$];
      logic [3:0] mode_data;
      logic [3:0] width_data;
      int         total;
      int         count;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_byte = 8'h00;
      csr_valid     = 1'b0;
      csr_index     = chce_pkg::CSR_MODE_SELECT;
      csr_data      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: Hamming, eight data bits
      chars = {8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5};
      send_list(chars);
      finish_phase();

      // seven data bits, top bit of the character must be ignored;
      // upper bits of the mode write are don't-care
      apply_config(4'hE, chce_pkg::WIDTH_SEVEN);
      chars = {8'h80, 8'hFF, 8'h7F, 8'h00, 8'h2A};
      send_list(chars);
      finish_phase();

      apply_config({3'b000, chce_pkg::MODE_CRC}, chce_pkg::WIDTH_SEVEN);
      chars = {8'h00, 8'hFF, 8'h80, 8'h01, 8'h31};
      send_list(chars);
      finish_phase();

      // width codes other than seven behave as eight
      apply_config({3'b000, chce_pkg::MODE_HAMMING}, 4'd0);
      chars = {8'hFF, 8'h5A};
      send_list(chars);
      finish_phase();
      apply_config({3'b000, chce_pkg::MODE_HAMMING}, 4'd15);
      chars = {8'h80, 8'h3C};
      send_list(chars);
      finish_phase();

      total = 0;
      while (total < RANDOM_CHARS) begin
         mode_data = 4'($urandom_range(0, 15));
         case ($urandom_range(0, 3))
            0, 1:    width_data = chce_pkg::WIDTH_SEVEN;
            2:       width_data = chce_pkg::WIDTH_RESET;
            default: width_data = 4'($urandom_range(0, 15));
         endcase
         apply_config(mode_data, width_data);
         count = $urandom_range(15, 60);
         if (count > RANDOM_CHARS - total)
            count = RANDOM_CHARS - total;
         repeat (count) send_char(8'($urandom_range(0, 255)));
         finish_phase();
         total += count;
      end

      repeat (8) @(negedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("PASS char_hamming_crc_encoder_top");
      else
         $display("FAIL char_hamming_crc_encoder_top");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/chce_pkg.sv
sv/chce_front.sv
sv/chce_queue.sv
sv/chce_back.sv
sv/char_hamming_crc_encoder_top.sv
sv/chce_checker.sv
dv/testbench.sv
